// ----- rtl/core/agw_pkg.sv -----
package agw_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int WEIGHT_BITS_DEF  = 16;

	localparam int FUNC_W     = 3;
	localparam int VERTEX_W   = 4;
	localparam int WEIGHT_W   = 16;
	localparam int COUNT_W    = 8;
	localparam int NUM_VERT_W = 5;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	localparam logic [NUM_VERT_W-1:0] NUM_VERT_RST = 5'd16;

	// results of one walk
	localparam int RESULT_CAP = 16;
	localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);
	localparam int VIS_IDX_W  = $clog2(RESULT_CAP);

	localparam logic [COUNT_W-1:0] COUNT_SAT = 8'hFF;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD    = 3'd0,
		FUNC_REMOVE = 3'd1,
		FUNC_READ   = 3'd2,
		FUNC_BFS    = 3'd3,
		FUNC_DFS    = 3'd4
	} func_t;

	typedef struct packed {
		func_t                      func;
		logic [VERTEX_W-1:0]        first_vertex;
		logic [VERTEX_W-1:0]        second_vertex;
		logic signed [WEIGHT_W-1:0] edge_weight;
	} op_t;

	typedef struct packed {
		logic                       status;
		logic [VERTEX_W-1:0]        visited_vertex;
		logic signed [WEIGHT_W-1:0] weight_read;
		logic [COUNT_W-1:0]         edge_count;
		logic                       last;
	} result_t;

endpackage

// ----- rtl/core/adjacency_matrix_graph_walker.sv -----
// Undirected weighted graph held as a square weight matrix in one synchronous RAM.
// Slave channel s_*: one operation per item, tuser selects it (add edge, remove edge,
// read weight, breadth-first walk, depth-first walk). Master channel m_*: one item per
// result; walks give one item per visited vertex, tlast marks the final item of an
// operation, tuser is the range-error status. cfg_wr_en/cfg_wr_data set the vertex
// count; write it only while no operation is in progress.
// Items are taken one at a time. Every operation ends with a sweep of the active
// n x n square (n = vertex count) at one RAM read per cycle to recount edges. Add and
// remove write both mirrored entries and read fetches one; a breadth-first walk scans
// one matrix row per visited vertex, and a depth-first walk rescans a row from the
// start on each step down or back.
// After reset the matrix RAM is cleared one entry a cycle, all (2**clog2(MAX_VERTICES))**2
// entries (256 at 16 vertices); s_tready stays low until the pass ends.
// Results go through an output register: a stalled receiver holds the current item
// and the remaining results of the operation wait behind it; nothing is dropped.
module adjacency_matrix_graph_walker #(
	parameter int MAX_VERTICES = agw_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = agw_pkg::WEIGHT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// first_vertex [3:0], second_vertex [7:4], edge_weight [23:8]
	input  logic [agw_pkg::IN_DATA_W-1:0]      s_tdata,
	// func [2:0]
	input  logic [agw_pkg::FUNC_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// visited_vertex [3:0], weight_read [19:4], edge_count [27:20], zeros [31:28]
	output logic [agw_pkg::OUT_DATA_W-1:0]     m_tdata,
	// status [0]
	output logic                               m_tuser,
	output logic                               m_tlast,
	input  logic                               cfg_wr_en,
	input  logic [agw_pkg::NUM_VERT_W-1:0]     cfg_wr_data
);
	import agw_pkg::*;

	localparam int VB = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int AW = 2 * VB;

	logic [NUM_VERT_W-1:0]  num_vertices_q;
	logic [NW-1:0]          active_n;
	op_t                    op;
	result_t                res;
	logic                   res_valid;
	logic                   res_ready;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [WEIGHT_BITS-1:0] mem_wdata;
	logic [AW-1:0]          mem_raddr;
	logic [WEIGHT_BITS-1:0] mem_rdata;
	logic                   clr_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vertices_q <= NUM_VERT_RST;
		end else if (cfg_wr_en) begin
			num_vertices_q <= cfg_wr_data;
		end
	end

	assign active_n = (32'(num_vertices_q) > MAX_VERTICES) ? NW'(MAX_VERTICES)
		: NW'(num_vertices_q);

	always_comb begin
		op.func          = func_t'(s_tuser);
		op.first_vertex  = s_tdata[3:0];
		op.second_vertex = s_tdata[7:4];
		op.edge_weight   = s_tdata[23:8];
	end

	agw_matrix #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (mem_we),
		.waddr    (mem_waddr),
		.wdata    (mem_wdata),
		.raddr    (mem_raddr),
		.rdata    (mem_rdata),
		.clr_busy (clr_busy)
	);

	agw_seq #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.active_n  (active_n),
		.clr_busy  (clr_busy),
		.op_valid  (s_tvalid),
		.op_ready  (s_tready),
		.op        (op),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	agw_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- rtl/core/agw_matrix.sv -----
module agw_matrix #(
	parameter int MAX_VERTICES = agw_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = agw_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      we,
	input  logic [2*$clog2(MAX_VERTICES)-1:0]         waddr,
	input  logic [WEIGHT_BITS-1:0]                    wdata,
	input  logic [2*$clog2(MAX_VERTICES)-1:0]         raddr,
	output logic [WEIGHT_BITS-1:0]                    rdata,
	output logic                                      clr_busy
);
	import agw_pkg::*;

	localparam int VB    = $clog2(MAX_VERTICES);
	localparam int AW    = 2 * VB;
	localparam int DEPTH = 1 << AW;

	logic [WEIGHT_BITS-1:0] weight_mem [DEPTH];
	logic [WEIGHT_BITS-1:0] rdata_q;
	logic                   clr_busy_q;
	logic [AW-1:0]          clr_addr_q;

	// sweep zeros through every row after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			weight_mem[clr_addr_q] <= '0;
		end else if (we) begin
			weight_mem[waddr] <= wdata;
		end
		rdata_q <= weight_mem[raddr];
	end

	assign rdata    = rdata_q;
	assign clr_busy = clr_busy_q;

endmodule

// ----- rtl/core/agw_seq.sv -----
module agw_seq #(
	parameter int MAX_VERTICES = agw_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = agw_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]     active_n,
	input  logic                                  clr_busy,
	input  logic                                  op_valid,
	output logic                                  op_ready,
	input  agw_pkg::op_t                          op,
	output logic                                  mem_we,
	output logic [2*$clog2(MAX_VERTICES)-1:0]     mem_waddr,
	output logic [WEIGHT_BITS-1:0]                mem_wdata,
	output logic [2*$clog2(MAX_VERTICES)-1:0]     mem_raddr,
	input  logic [WEIGHT_BITS-1:0]                mem_rdata,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output agw_pkg::result_t                      res
);
	import agw_pkg::*;

	localparam int VB = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int CW = $clog2(MAX_VERTICES * MAX_VERTICES + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WR_A,
		ST_WR_B,
		ST_RD,
		ST_RD_WAIT,
		ST_BFS_POP,
		ST_BFS_LOAD,
		ST_BFS_SCAN,
		ST_DFS_SCAN,
		ST_DFS_LOAD,
		ST_COUNT,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	op_t                     op_q;
	logic                    status_q;
	logic                    is_walk_q;
	logic [WEIGHT_W-1:0]     rd_weight_q;
	logic [RES_CNT_W-1:0]    cnt_q;
	logic [RES_CNT_W-1:0]    emit_q;
	logic [VERTEX_W-1:0]     visits_q [RESULT_CAP];
	logic [MAX_VERTICES-1:0] marks_q;
	logic [NW-1:0]           head_q;
	logic [NW-1:0]           tail_q;
	logic [NW-1:0]           sp_q;
	logic [VB-1:0]           cur_q;
	logic [NW-1:0]           i_q;
	logic [VB-1:0]           i_s1;
	logic                    vld_s1;
	logic [NW-1:0]           row_q;
	logic [NW-1:0]           col_q;
	logic [CW-1:0]           nz_q;

	// queue for breadth-first, stack for depth-first
	logic [VB-1:0] walk_mem [MAX_VERTICES];
	logic [VB-1:0] wl_rdata_q;
	logic          wl_we;
	logic [VB-1:0] wl_waddr;
	logic [VB-1:0] wl_wdata;
	logic [VB-1:0] wl_raddr;

	logic [VB-1:0]        a_v;
	logic [VB-1:0]        b_v;
	logic                 a_bad;
	logic                 b_bad;
	logic                 is_edge_op;
	logic                 is_walk_op;
	logic                 range_err;
	logic signed [31:0]   wr_ext;
	logic signed [31:0]   rd_ext;
	logic                 hit;
	logic                 scan_more;
	logic                 tail_ok;
	logic                 sp_ok;
	logic                 push;
	logic                 do_pop;
	logic [NW-1:0]        sp_m2;
	logic [CW-2:0]        half_nz;
	logic [COUNT_W-1:0]   ec_val;

	assign a_v       = VB'(op_q.first_vertex);
	assign b_v       = VB'(op_q.second_vertex);
	assign a_bad     = 32'(op_q.first_vertex) >= 32'(active_n);
	assign b_bad     = 32'(op_q.second_vertex) >= 32'(active_n);
	assign is_edge_op = op_q.func inside {FUNC_ADD, FUNC_REMOVE, FUNC_READ};
	assign is_walk_op = op_q.func inside {FUNC_BFS, FUNC_DFS};
	assign range_err  = (is_edge_op && (a_bad || b_bad)) || (is_walk_op && a_bad);
	assign wr_ext    = 32'(op_q.edge_weight);
	assign rd_ext    = 32'(signed'(mem_rdata));
	assign hit       = vld_s1 && (|mem_rdata) && !marks_q[i_s1];
	assign scan_more = i_q < active_n;
	assign tail_ok   = 32'(tail_q) < MAX_VERTICES;
	assign sp_ok     = 32'(sp_q) < MAX_VERTICES;
	assign push      = (state_q == ST_DFS_SCAN) && hit && sp_ok;
	assign do_pop    = (state_q == ST_DFS_SCAN) &&
		((hit && !sp_ok) || (!hit && !scan_more && !vld_s1));
	assign sp_m2     = sp_q - NW'(2);
	assign half_nz   = nz_q[CW-1:1];
	assign ec_val    = (32'(half_nz) > 32'(COUNT_SAT)) ? COUNT_SAT : COUNT_W'(half_nz);

	assign op_ready  = (state_q == ST_IDLE) && !clr_busy;
	assign res_valid = (state_q == ST_EMIT);

	always_comb begin
		res.status         = status_q;
		res.visited_vertex = is_walk_q ? visits_q[emit_q[VIS_IDX_W-1:0]] : '0;
		res.weight_read    = rd_weight_q;
		res.edge_count     = ec_val;
		res.last           = (emit_q == cnt_q - RES_CNT_W'(1));
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {a_v, b_v};
		mem_wdata = (op_q.func == FUNC_ADD) ? wr_ext[WEIGHT_BITS-1:0] : '0;
		mem_raddr = {cur_q, VB'(i_q)};
		case (state_q)
			ST_WR_A: begin
				mem_we = 1'b1;
			end
			ST_WR_B: begin
				mem_we    = 1'b1;
				mem_waddr = {b_v, a_v};
			end
			ST_RD: begin
				mem_raddr = {a_v, b_v};
			end
			ST_COUNT: begin
				mem_raddr = {VB'(row_q), VB'(col_q)};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		wl_we    = 1'b0;
		wl_waddr = '0;
		wl_wdata = a_v;
		wl_raddr = head_q[VB-1:0];
		case (state_q)
			ST_DECODE: begin
				wl_we = 1'b1;
			end
			ST_BFS_SCAN: begin
				wl_we    = hit && tail_ok;
				wl_waddr = tail_q[VB-1:0];
				wl_wdata = i_s1;
			end
			ST_DFS_SCAN: begin
				wl_we    = push;
				wl_waddr = sp_q[VB-1:0];
				wl_wdata = i_s1;
				wl_raddr = sp_m2[VB-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wl_we) begin
			walk_mem[wl_waddr] <= wl_wdata;
		end
		wl_rdata_q <= walk_mem[wl_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			marks_q <= '0;
			cnt_q   <= '0;
			emit_q  <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			sp_q    <= '0;
			i_q     <= '0;
			row_q   <= '0;
			col_q   <= '0;
			nz_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (op_valid && op_ready) begin
						op_q    <= op;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					status_q    <= range_err ? STATUS_RANGE : STATUS_OK;
					is_walk_q   <= is_walk_op && !range_err;
					rd_weight_q <= '0;
					cnt_q       <= (op_q.func == FUNC_BFS && !range_err) ? '0 : RES_CNT_W'(1);
					row_q       <= '0;
					col_q       <= '0;
					nz_q        <= '0;
					vld_s1      <= 1'b0;
					i_q         <= '0;
					marks_q     <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_v;
					case (op_q.func)
						FUNC_ADD, FUNC_REMOVE, FUNC_READ: begin
							if (range_err) begin
								state_q <= ST_COUNT;
							end else if (op_q.func == FUNC_READ) begin
								state_q <= ST_RD;
							end else begin
								state_q <= ST_WR_A;
							end
						end
						FUNC_BFS: begin
							if (range_err) begin
								state_q <= ST_COUNT;
							end else begin
								head_q  <= '0;
								tail_q  <= NW'(1);
								state_q <= ST_BFS_POP;
							end
						end
						FUNC_DFS: begin
							if (range_err) begin
								state_q <= ST_COUNT;
							end else begin
								visits_q[0] <= VERTEX_W'(a_v);
								sp_q        <= NW'(1);
								cur_q       <= a_v;
								state_q     <= ST_DFS_SCAN;
							end
						end
						default: begin
							state_q <= ST_COUNT;
						end
					endcase
				end
				ST_WR_A: begin
					state_q <= ST_WR_B;
				end
				ST_WR_B: begin
					state_q <= ST_COUNT;
				end
				ST_RD: begin
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					rd_weight_q <= rd_ext[WEIGHT_W-1:0];
					state_q     <= ST_COUNT;
				end
				ST_BFS_POP: begin
					if (head_q < tail_q && 32'(cnt_q) < RESULT_CAP) begin
						head_q  <= head_q + NW'(1);
						state_q <= ST_BFS_LOAD;
					end else begin
						state_q <= ST_COUNT;
					end
				end
				ST_BFS_LOAD: begin
					cur_q                            <= wl_rdata_q;
					visits_q[cnt_q[VIS_IDX_W-1:0]]   <= VERTEX_W'(wl_rdata_q);
					cnt_q                            <= cnt_q + RES_CNT_W'(1);
					i_q                              <= '0;
					vld_s1                           <= 1'b0;
					state_q                          <= ST_BFS_SCAN;
				end
				ST_BFS_SCAN: begin
					if (scan_more) begin
						i_s1   <= VB'(i_q);
						i_q    <= i_q + NW'(1);
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (hit && tail_ok) begin
						tail_q        <= tail_q + NW'(1);
						marks_q[i_s1] <= 1'b1;
					end
					if (!scan_more && !vld_s1) begin
						state_q <= ST_BFS_POP;
					end
				end
				ST_DFS_SCAN: begin
					// drop the read in flight once a neighbour is found
					if (hit) begin
						vld_s1 <= 1'b0;
						i_q    <= '0;
					end else if (scan_more) begin
						i_s1   <= VB'(i_q);
						i_q    <= i_q + NW'(1);
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (push) begin
						marks_q[i_s1]                  <= 1'b1;
						visits_q[cnt_q[VIS_IDX_W-1:0]] <= VERTEX_W'(i_s1);
						cnt_q                          <= cnt_q + RES_CNT_W'(1);
						sp_q                           <= sp_q + NW'(1);
						cur_q                          <= i_s1;
						if (cnt_q == RES_CNT_W'(RESULT_CAP - 1)) begin
							state_q <= ST_COUNT;
						end
					end
					if (do_pop) begin
						sp_q <= sp_q - NW'(1);
						if (sp_q == NW'(1)) begin
							state_q <= ST_COUNT;
						end else begin
							state_q <= ST_DFS_LOAD;
						end
					end
				end
				ST_DFS_LOAD: begin
					// rescan the parent from the start; earlier entries stay rejected
					cur_q   <= wl_rdata_q;
					i_q     <= '0;
					vld_s1  <= 1'b0;
					state_q <= ST_DFS_SCAN;
				end
				ST_COUNT: begin
					if (row_q < active_n) begin
						vld_s1 <= 1'b1;
						if (col_q == active_n - NW'(1)) begin
							col_q <= '0;
							row_q <= row_q + NW'(1);
						end else begin
							col_q <= col_q + NW'(1);
						end
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1 && (|mem_rdata)) begin
						nz_q <= nz_q + CW'(1);
					end
					if (!(row_q < active_n) && !vld_s1) begin
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						emit_q <= emit_q + RES_CNT_W'(1);
						if (res.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(tail_q) <= MAX_VERTICES) && (32'(sp_q) <= MAX_VERTICES))
		else $error("walk list index beyond its depth");

	a_visit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= RESULT_CAP)
		else $error("more visits recorded than results allowed");

	a_start_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BFS_SCAN || state_q == ST_DFS_SCAN) |-> marks_q[a_v])
		else $error("start vertex lost its visited mark during a walk");

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (op_q.func == FUNC_ADD || op_q.func == FUNC_REMOVE))
		else $error("matrix written by an operation other than add or remove");

	a_emit_after_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q) == ST_COUNT)
		else $error("result offered before the edge count sweep finished");
`endif

endmodule

// ----- rtl/core/agw_out.sv -----
module agw_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               res_valid,
	output logic                               res_ready,
	input  agw_pkg::result_t                   res,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [agw_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                               m_tuser,
	output logic                               m_tlast
);
	import agw_pkg::*;

	localparam int PAD_W = OUT_DATA_W - VERTEX_W - WEIGHT_W - COUNT_W;

	logic    vld_q;
	result_t res_q;

	// take a new item whenever the register is empty or being drained
	assign res_ready = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res_ready) begin
			vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {{PAD_W{1'b0}}, res_q.edge_count, res_q.weight_read, res_q.visited_vertex};
	assign m_tuser  = res_q.status;
	assign m_tlast  = res_q.last;

endmodule
